[rtl/tcp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_pkg
// Shared types and constants of the timestamp cadence predictor.
// ----------------------------------------------------------------------------
package tcp_pkg;

    localparam int TS_W  = 64;
    localparam int CMD_W = 2;
    localparam int CFG_W = 8;
    localparam int CNT_W = 7;

    localparam int JUMP_SHIFT   = 5;    // jump limit is 32 times window_high
    localparam int PERCENT_ERR  = 25;
    localparam int PERCENT_FULL = 100;

    localparam logic [CFG_W-1:0] DEFAULT_REORDER = 8'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_FEED  = 2'd0,
        CMD_HINT  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t            cmd;
        logic [TS_W-1:0] ts;
    } item_t;

endpackage
`default_nettype wire

[rtl/tcp_item_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_item_if
// Input item channel: command and timestamp.
// ----------------------------------------------------------------------------
interface tcp_item_if
    import tcp_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [TS_W-1:0]  timestamp;

    modport source (output valid, output command, output timestamp, input ready);
    modport sink   (input valid, input command, input timestamp, output ready);
endinterface
`default_nettype wire

[rtl/tcp_result_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_result_if
// Result item channel: is_next flag.
// ----------------------------------------------------------------------------
interface tcp_result_if;
    logic valid;
    logic ready;
    logic is_next;

    modport source (output valid, output is_next, input ready);
    modport sink   (input valid, input is_next, output ready);
endinterface
`default_nettype wire

[rtl/tcp_cfg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_cfg_if
// Configuration write channel for the reorder-depth register.
// ----------------------------------------------------------------------------
interface tcp_cfg_if
    import tcp_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] max_reorder_frames;

    modport source (output valid, output max_reorder_frames, input ready);
    modport sink   (input valid, input max_reorder_frames, output ready);
endinterface
`default_nettype wire

[rtl/tcp_window_calc.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_window_calc
// Window bounds step -/+ ((step * 25) mod 2^N) / 100, without a divider.
// With 25*step = k*2^N + r and step = 4a + b:
//   r / 100 = a - Q[k] - (25b < R[k]),  k*2^N = 100*Q[k] + R[k].
// ----------------------------------------------------------------------------
module tcp_window_calc
    import tcp_pkg::*;
#(
    parameter int N = 64
)
(
    input  wire logic [N-1:0] step,
    output logic      [N-1:0] win_low,
    output logic      [N-1:0] win_high
);

    localparam int KW = $clog2(PERCENT_ERR);
    localparam int RW = $clog2(PERCENT_FULL);

    logic [N-1:0]  q_tab [PERCENT_ERR];
    logic [RW-1:0] r_tab [PERCENT_ERR];

    for (genvar i = 0; i < PERCENT_ERR; i++)
    begin : g_tab
        localparam logic [N+KW:0] P = (N+KW+1)'(i) << N;
        localparam logic [N+KW:0] Q = P / PERCENT_FULL;
        localparam logic [N+KW:0] R = P % PERCENT_FULL;
        assign q_tab[i] = Q[N-1:0];
        assign r_tab[i] = R[RW-1:0];
    end

    logic [N+KW-1:0] step_x;
    logic [N+KW-1:0] prod;
    logic [KW-1:0]   k;
    logic [RW-1:0]   b25;
    logic            borrow;
    logic [N-1:0]    margin;

    // 25 = 16 + 8 + 1
    assign step_x = {{KW{1'b0}}, step};
    assign prod   = (step_x << 4) + (step_x << 3) + step_x;
    assign k      = prod[N+KW-1:N];
    assign b25    = RW'(step[1:0]) * RW'(PERCENT_ERR);
    assign borrow = (b25 < r_tab[k]);
    assign margin = (step >> 2) - q_tab[k] - N'(borrow);

    assign win_low  = step - margin;
    assign win_high = step + margin;

endmodule
`default_nettype wire

[rtl/tcp_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_core
// Predictor state and its single-pass update for one item.
// ----------------------------------------------------------------------------
module tcp_core
    import tcp_pkg::*;
#(
    parameter int N = 64
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire item_t            item,
    input  wire logic             fire,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_data,
    output logic                  is_next
);

    localparam logic [N-1:0] INVALID = '1;

    logic [N-1:0]     last_fed_reg,    last_fed_next;
    logic [N-1:0]     last_hinted_reg, last_hinted_next;
    logic [N-1:0]     win_low_reg,     win_low_next;
    logic [N-1:0]     win_high_reg,    win_high_next;
    logic [CNT_W-1:0] count_reg,       count_next;
    logic [CFG_W-1:0] max_reorder_reg, max_reorder_next;

    logic [N-1:0]     ts;
    logic [N-1:0]     ref_ts;
    logic [N-1:0]     step;
    logic [N-1:0]     calc_low;
    logic [N-1:0]     calc_high;
    logic [N-1:0]     diff;
    logic [CNT_W-1:0] reload;
    logic [CFG_W-1:0] cfg_val;

    assign ts     = item.ts[N-1:0];
    assign reload = max_reorder_reg[CFG_W-1:1];
    assign ref_ts = (item.cmd == CMD_HINT) ? last_hinted_reg : last_fed_reg;
    assign step   = (ts > ref_ts) ? (ts - ref_ts) : (ref_ts - ts);
    assign diff   = ts - last_hinted_reg;

    tcp_window_calc #(
        .N (N)
    ) u_window (
        .step     (step),
        .win_low  (calc_low),
        .win_high (calc_high)
    );

    always_comb
    begin
        last_fed_next    = last_fed_reg;
        last_hinted_next = last_hinted_reg;
        win_low_next     = win_low_reg;
        win_high_next    = win_high_reg;
        count_next       = count_reg;
        max_reorder_next = max_reorder_reg;
        is_next          = 1'b0;
        cfg_val          = (cfg_data == '0) ? DEFAULT_REORDER : cfg_data;

        if (cfg_we)
        begin
            max_reorder_next = cfg_val;
            last_fed_next    = INVALID;
            last_hinted_next = INVALID;
            win_low_next     = '0;
            win_high_next    = '0;
            count_next       = cfg_val[CFG_W-1:1];
        end
        else if (fire)
        begin
            case (item.cmd)
                CMD_FEED:
                begin
                    if (ts != last_fed_reg)
                    begin
                        if (last_fed_reg != INVALID)
                        begin
                            if (win_high_reg != '0 && step > (win_high_reg << JUMP_SHIFT))
                            begin
                                last_fed_next    = INVALID;
                                last_hinted_next = INVALID;
                                win_low_next     = '0;
                                win_high_next    = '0;
                                count_next       = reload;
                            end
                            else if (step != '0)
                            begin
                                if (win_low_reg == '0 || step < win_low_reg)
                                begin
                                    win_low_next  = calc_low;
                                    win_high_next = calc_high;
                                    count_next    = reload;
                                end
                                else if (count_reg != '0)
                                begin
                                    count_next = count_reg - 1'b1;
                                end
                            end
                        end
                        // high-to-low check sees the state after step handling
                        if (count_next != '0 && last_fed_next > ts && last_hinted_next > ts)
                        begin
                            count_next = reload;
                        end
                        last_fed_next = ts;
                        if (last_hinted_next == INVALID)
                        begin
                            last_hinted_next = ts;
                        end
                    end
                end
                CMD_HINT:
                begin
                    if (ts != last_hinted_reg && last_hinted_reg != INVALID)
                    begin
                        if (ts < last_hinted_reg)
                        begin
                            last_fed_next = INVALID;
                            win_low_next  = '0;
                            win_high_next = '0;
                            count_next    = reload;
                        end
                        else if (step != '0)
                        begin
                            if (win_low_reg == '0 || step < win_low_reg)
                            begin
                                win_low_next  = calc_low;
                                win_high_next = calc_high;
                                count_next    = reload;
                            end
                            else if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        last_hinted_next = ts;
                    end
                end
                CMD_QUERY:
                begin
                    if (count_reg != '0)
                        is_next = 1'b0;
                    else if (ts == last_hinted_reg)
                        is_next = 1'b1;
                    else if (ts < last_hinted_reg)
                        is_next = 1'b0;
                    else if (diff[N-1])
                        is_next = 1'b0;
                    else
                        is_next = (win_low_reg <= diff) && (diff <= win_high_reg);
                end
                default:
                begin
                    is_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_fed_reg    <= INVALID;
            last_hinted_reg <= INVALID;
            win_low_reg     <= '0;
            win_high_reg    <= '0;
            count_reg       <= DEFAULT_REORDER[CFG_W-1:1];
            max_reorder_reg <= DEFAULT_REORDER;
        end
        else
        begin
            last_fed_reg    <= last_fed_next;
            last_hinted_reg <= last_hinted_next;
            win_low_reg     <= win_low_next;
            win_high_reg    <= win_high_next;
            count_reg       <= count_next;
            max_reorder_reg <= max_reorder_next;
        end
    end

endmodule
`default_nettype wire

[rtl/timestamp_cadence_predictor_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// timestamp_cadence_predictor_top
// Learns the frame timestamp step from feed and hint items and answers
// is-next queries.
// ----------------------------------------------------------------------------
// Every accepted item gives exactly one result item (is_next, 0 for feed and
// hint). The block takes one item per clock unless the result side holds it:
// an accepted item sits in the input register while the state update and
// answer are formed in a single pass, and the answer lands in the output
// register, from which the result is offered. Back-pressure on the result
// side holds the input register and then lowers items.ready. Writing
// max_reorder_frames clears all learned state; write it only while no item is
// in flight. Timestamps use their low STAMP_BITS bits.
// ----------------------------------------------------------------------------
module timestamp_cadence_predictor_top
    import tcp_pkg::*;
#(
    parameter int STAMP_BITS = 64
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    tcp_item_if.sink    items,
    tcp_result_if.source results,
    tcp_cfg_if.sink     cfg
);

    logic  in_valid_reg;
    item_t item_reg;
    logic  out_valid_reg;
    logic  is_next_reg;
    logic  advance;
    logic  in_take;
    logic  core_is_next;

    assign advance       = in_valid_reg && (!out_valid_reg || results.ready);
    assign items.ready   = !in_valid_reg || advance;
    assign in_take       = items.valid && items.ready;
    assign cfg.ready     = 1'b1;
    assign results.valid   = out_valid_reg;
    assign results.is_next = is_next_reg;

    tcp_core #(
        .N (STAMP_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_reg),
        .fire     (advance),
        .cfg_we   (cfg.valid),
        .cfg_data (cfg.max_reorder_frames),
        .is_next  (core_is_next)
    );

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.cmd <= cmd_t'(items.command);
            item_reg.ts  <= items.timestamp;
        end
        if (advance)
        begin
            is_next_reg <= core_is_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire
